// ----- hdl/pli_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the piecewise linear interpolator
// no dependencies
package pli_pkg;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] REGION_BELOW  = 2'd0;
    localparam logic [1:0] REGION_INSIDE = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    localparam logic [1:0] CFG_COUNT = 2'd0;
    localparam logic [1:0] CFG_BELOW = 2'd1;
    localparam logic [1:0] CFG_ABOVE = 2'd2;

    localparam logic [4:0] COUNT_MIN = 5'd2;

    // search probe that walks the cell row
    typedef struct packed {
        logic               done;
        logic [1:0]         region;
        logic [3:0]         seg;
        logic               last;
        logic signed [31:0] x;
        logic signed [31:0] y0;
        logic [32:0]        t;
        logic [32:0]        dx;
        logic signed [32:0] dy;
    } probe_t;

    typedef struct packed {
        logic signed [31:0] y;
        logic [1:0]         region;
        logic [3:0]         seg;
        logic               last;
    } res_t;

endpackage

// ----- hdl/pli_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for input items and results
// no dependencies
interface pli_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] sample_x;
    logic               last;

    modport source (output valid, action, point_index, point_x, point_y, sample_x, last,
                    input ready);
    modport sink (input valid, action, point_index, point_x, point_y, sample_x, last,
                  output ready);
endinterface

interface pli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] y_value;
    logic [1:0]         region;
    logic [3:0]         segment;
    logic               last_out;

    modport source (output valid, y_value, region, segment, last_out, input ready);
    modport sink (input valid, y_value, region, segment, last_out, output ready);
endinterface

// ----- hdl/piecewise_linear_interpolator_core.sv -----
`timescale 1ns / 1ps
// A load item writes one breakpoint cell and gives no result.
// A sample item travels through a row of MAX_POINTS breakpoint cells, one per
// cycle, then through a divide unit that settles one quotient step per cycle;
// a sample below or above the table skips the divide. The input stays closed
// from a sample's transfer until its result moves into the output register, so
// only one sample is in flight at a time. The result sits in an output register,
// so the next item may transfer while it waits; a result still waiting there when
// the next sample's result is ready stalls the input until it transfers.
// Breakpoint entries must be loaded before a sample reads them.
// top level; depends on pli_pkg, pli_if, pli_cell, pli_div
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    pli_in_if.sink      in_ch,
    pli_out_if.source   out_ch
);

    logic [4:0]         count_reg;
    logic signed [31:0] below_reg;
    logic signed [31:0] above_reg;
    logic [4:0]         n_eff;
    logic               busy_reg;
    logic               out_valid_reg;
    pli_pkg::res_t      out_reg;

    logic               in_xfer;
    logic               load_en;
    logic               launch;
    pli_pkg::probe_t    launch_probe;

    logic [MAX_POINTS-1:0] pv;
    pli_pkg::probe_t       pp [MAX_POINTS];
    logic signed [31:0]    px [MAX_POINTS];
    logic signed [31:0]    py [MAX_POINTS];

    pli_pkg::probe_t    end_probe;
    logic signed [31:0] bound_y;
    logic               div_valid;
    pli_pkg::res_t      div_res;
    logic               take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= pli_pkg::COUNT_MIN;
            below_reg <= '0;
            above_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pli_pkg::CFG_COUNT: count_reg <= cfg_data[4:0];
                pli_pkg::CFG_BELOW: below_reg <= cfg_data;
                pli_pkg::CFG_ABOVE: above_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        if (count_reg < pli_pkg::COUNT_MIN)
        begin
            n_eff = pli_pkg::COUNT_MIN;
        end
        else if (int'(count_reg) > MAX_POINTS)
        begin
            n_eff = 5'(MAX_POINTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    assign in_ch.ready = !busy_reg;
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign load_en     = in_xfer && (in_ch.action == pli_pkg::ACT_LOAD);
    assign launch      = in_xfer && (in_ch.action == pli_pkg::ACT_SAMPLE);

    always_comb
    begin
        launch_probe        = '0;
        launch_probe.region = pli_pkg::REGION_ABOVE;
        launch_probe.x      = in_ch.sample_x;
        launch_probe.last   = in_ch.last;
    end

    genvar i;
    generate
        for (i = 0; i < MAX_POINTS; i++)
        begin : g_cell
            logic               c_in_valid;
            pli_pkg::probe_t    c_in_probe;
            logic signed [31:0] c_nb_x;
            logic signed [31:0] c_nb_y;

            if (i == 0)
            begin : g_first
                assign c_in_valid = launch;
                assign c_in_probe = launch_probe;
            end
            else
            begin : g_rest
                assign c_in_valid = pv[i-1];
                assign c_in_probe = pp[i-1];
            end

            if (i == MAX_POINTS - 1)
            begin : g_end
                assign c_nb_x = px[i];
                assign c_nb_y = py[i];
            end
            else
            begin : g_mid
                assign c_nb_x = px[i+1];
                assign c_nb_y = py[i+1];
            end

            pli_cell #(
                .IDX (i)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (load_en),
                .wr_index  (in_ch.point_index),
                .wr_x      (in_ch.point_x),
                .wr_y      (in_ch.point_y),
                .n_cnt     (n_eff),
                .nb_x      (c_nb_x),
                .nb_y      (c_nb_y),
                .in_valid  (c_in_valid),
                .in_probe  (c_in_probe),
                .out_valid (pv[i]),
                .out_probe (pp[i]),
                .pt_x      (px[i]),
                .pt_y      (py[i])
            );
        end
    endgenerate

    assign end_probe = pp[MAX_POINTS-1];
    assign bound_y   = (end_probe.region == pli_pkg::REGION_BELOW) ? below_reg : above_reg;
    assign take      = div_valid && (!out_valid_reg || out_ch.ready);

    pli_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pv[MAX_POINTS-1]),
        .probe     (end_probe),
        .bound_y   (bound_y),
        .take      (take),
        .res_valid (div_valid),
        .res       (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (launch)
            begin
                busy_reg <= 1'b1;
            end
            else if (take)
            begin
                busy_reg <= 1'b0;
            end

            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= div_res;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.y_value  = out_reg.y;
    assign out_ch.region   = out_reg.region;
    assign out_ch.segment  = out_reg.seg;
    assign out_ch.last_out = out_reg.last;

    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pv) <= 1)
        else $error("more than one probe in the cell row");

    a_busy_while_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (|pv) |-> busy_reg)
        else $error("probe in flight while input is open");

    a_boundary_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.region != pli_pkg::REGION_INSIDE) |-> out_ch.segment == 4'd0)
        else $error("boundary result with nonzero segment");

    a_take_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !busy_reg)
        else $error("input still blocked after result transfer");

endmodule

// ----- hdl/pli_cell.sv -----
`timescale 1ns / 1ps
// one breakpoint cell: holds one (x, y) entry and tests one segment per probe
// depends on pli_pkg
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [3:0]         wr_index,
    input  logic signed [31:0] wr_x,
    input  logic signed [31:0] wr_y,
    input  logic [4:0]         n_cnt,
    input  logic signed [31:0] nb_x,
    input  logic signed [31:0] nb_y,
    input  logic               in_valid,
    input  pli_pkg::probe_t    in_probe,
    output logic               out_valid,
    output pli_pkg::probe_t    out_probe,
    output logic signed [31:0] pt_x,
    output logic signed [31:0] pt_y
);

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic               valid_reg;
    pli_pkg::probe_t    probe_reg;
    pli_pkg::probe_t    probe_next;
    logic               active;

    assign active = (IDX + 1) < int'(n_cnt);

    always_ff @(posedge clk)
    begin
        if (wr_en && (IDX < 16) && (wr_index == 4'(IDX)))
        begin
            x_reg <= wr_x;
            y_reg <= wr_y;
        end
    end

    always_comb
    begin
        probe_next = in_probe;
        if (!in_probe.done && active && (in_probe.x < nb_x))
        begin
            probe_next.done = 1'b1;
            if (in_probe.x >= x_reg)
            begin
                probe_next.region = pli_pkg::REGION_INSIDE;
                probe_next.seg    = 4'(IDX);
                probe_next.y0     = y_reg;
                probe_next.t      = {in_probe.x[31], in_probe.x} - {x_reg[31], x_reg};
                probe_next.dx     = {nb_x[31], nb_x} - {x_reg[31], x_reg};
                probe_next.dy     = {nb_y[31], nb_y} - {y_reg[31], y_reg};
            end
            else
            begin
                probe_next.region = pli_pkg::REGION_BELOW;
                probe_next.seg    = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            probe_reg <= probe_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_probe = probe_reg;
    assign pt_x      = x_reg;
    assign pt_y      = y_reg;

endmodule

// ----- hdl/pli_div.sv -----
`timescale 1ns / 1ps
// scaled divide unit: y0 + dy * t / dx, one quotient step per cycle, saturated
// depends on pli_pkg
module pli_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pli_pkg::probe_t    probe,
    input  logic signed [31:0] bound_y,
    input  logic               take,
    output logic               res_valid,
    output pli_pkg::res_t      res
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;
    localparam logic [5:0] STEPS  = 6'd33;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

    logic [1:0]         state_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        r_reg;
    logic [32:0]        q_reg;
    logic [32:0]        mag_reg;
    logic [32:0]        t_reg;
    logic [32:0]        dx_reg;
    logic               neg_reg;
    logic signed [31:0] y0_reg;
    pli_pkg::res_t      res_reg;

    logic [34:0]        s;
    logic [34:0]        dx1;
    logic [34:0]        dx2;
    logic [32:0]        r_next;
    logic [32:0]        q_next;
    logic signed [34:0] qs;
    logic signed [34:0] sum;
    logic signed [31:0] y_sat;

    always_comb
    begin
        dx1 = {2'b00, dx_reg};
        dx2 = {1'b0, dx_reg, 1'b0};
        s   = {1'b0, r_reg, 1'b0} + (mag_reg[32] ? {2'b00, t_reg} : 35'd0);
        if (s >= dx2)
        begin
            r_next = 33'(s - dx2);
            q_next = {q_reg[31:0], 1'b0} + 33'd2;
        end
        else if (s >= dx1)
        begin
            r_next = 33'(s - dx1);
            q_next = {q_reg[31:0], 1'b0} + 33'd1;
        end
        else
        begin
            r_next = s[32:0];
            q_next = {q_reg[31:0], 1'b0};
        end
    end

    always_comb
    begin
        qs  = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        sum = 35'(y0_reg) + qs;
        if (sum > SAT_MAX)
        begin
            y_sat = 32'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            y_sat = 32'(SAT_MIN);
        end
        else
        begin
            y_sat = sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= STEPS;
                        state_reg <= (probe.region == pli_pkg::REGION_INSIDE) ? D_RUN : D_DONE;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN:
                begin
                    state_reg <= D_DONE;
                end
                D_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            r_reg          <= 33'd0;
            q_reg          <= 33'd0;
            mag_reg        <= probe.dy[32] ? 33'(-probe.dy) : 33'(probe.dy);
            neg_reg        <= probe.dy[32];
            t_reg          <= probe.t;
            dx_reg         <= probe.dx;
            y0_reg         <= probe.y0;
            res_reg.region <= probe.region;
            res_reg.seg    <= probe.seg;
            res_reg.last   <= probe.last;
            res_reg.y      <= bound_y;
        end
        else if (state_reg == D_RUN)
        begin
            r_reg   <= r_next;
            q_reg   <= q_next;
            mag_reg <= {mag_reg[31:0], 1'b0};
        end
        else if (state_reg == D_FIN)
        begin
            res_reg.y <= y_sat;
        end
    end

    assign res_valid = (state_reg == D_DONE);
    assign res       = res_reg;

endmodule

// ----- bench/pli_result_check.sv -----
`timescale 1ns / 1ps
// watches the config port and both channels, keeps its own breakpoint table
// and predicts each sample result; depends on pli_pkg and pli_if
module pli_result_check (
    input  logic clk,
    input  logic rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    pli_in_if    in_ch,
    pli_out_if   out_ch,
    output int   errors,
    output int   pending
);

    localparam int NPTS = 16;

    logic signed [31:0] tab_x [NPTS];
    logic signed [31:0] tab_y [NPTS];
    logic [4:0]         cnt;
    logic signed [31:0] below_v;
    logic signed [31:0] above_v;
    pli_pkg::res_t      want_q [$];

    function automatic pli_pkg::res_t interpolate(logic signed [31:0] sx, logic lst);
        pli_pkg::res_t      r;
        int                 n;
        bit                 found;
        longint             x, x0, x1, y0, dy, dx, q, s;
        longint unsigned    mag, t, qa, ra, m;
        r.y      = above_v;
        r.region = pli_pkg::REGION_ABOVE;
        r.seg    = 4'd0;
        r.last   = lst;
        n = cnt;
        if (n < 2) n = 2;
        if (n > NPTS) n = NPTS;
        x = sx;
        found = 0;
        for (int k = 0; k + 1 < n; k++)
        begin
            x0 = tab_x[k];
            x1 = tab_x[k + 1];
            if (!found && x < x1)
            begin
                found = 1;
                if (x >= x0)
                begin
                    y0 = tab_y[k];
                    dy = longint'(tab_y[k + 1]) - y0;
                    dx = x1 - x0;
                    q  = 0;
                    if (dx > 0)
                    begin
                        mag = (dy < 0) ? longint'(-dy) : dy;
                        t   = x - x0;
                        qa  = mag / longint'(dx);
                        ra  = mag % longint'(dx);
                        m   = qa * t + (ra * t) / longint'(dx);
                        q   = (dy < 0) ? -longint'(m) : longint'(m);
                    end
                    s = y0 + q;
                    if (s > 64'sd2147483647) s = 64'sd2147483647;
                    if (s < -64'sd2147483648) s = -64'sd2147483648;
                    r.y      = s[31:0];
                    r.region = pli_pkg::REGION_INSIDE;
                    r.seg    = k[3:0];
                end
                else
                begin
                    r.y      = below_v;
                    r.region = pli_pkg::REGION_BELOW;
                end
            end
        end
        return r;
    endfunction

    assign pending = want_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pli_pkg::res_t w;
        if (!rst_n)
        begin
            for (int i = 0; i < NPTS; i++)
            begin
                tab_x[i] = '0;
                tab_y[i] = '0;
            end
            cnt     = pli_pkg::COUNT_MIN;
            below_v = '0;
            above_v = '0;
            errors  = 0;
            want_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pli_pkg::CFG_COUNT: cnt     = cfg_data[4:0];
                    pli_pkg::CFG_BELOW: below_v = cfg_data;
                    pli_pkg::CFG_ABOVE: above_v = cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (want_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result y=%0d region=%0d seg=%0d last=%0b",
                                 out_ch.y_value, out_ch.region, out_ch.segment,
                                 out_ch.last_out);
                end
                else
                begin
                    w = want_q.pop_front();
                    if (w.y !== out_ch.y_value || w.region !== out_ch.region ||
                        w.seg !== out_ch.segment || w.last !== out_ch.last_out)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp y=%0d r=%0d s=%0d l=%0b ",
                                      "got y=%0d r=%0d s=%0d l=%0b"},
                                     w.y, w.region, w.seg, w.last, out_ch.y_value,
                                     out_ch.region, out_ch.segment, out_ch.last_out);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.action == pli_pkg::ACT_LOAD)
                begin
                    tab_x[in_ch.point_index] = in_ch.point_x;
                    tab_y[in_ch.point_index] = in_ch.point_y;
                end
                else
                    want_q.push_back(interpolate(in_ch.sample_x, in_ch.last));
            end
        end
    end

endmodule

// ----- bench/tb_piecewise_linear_interpolator_core.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the piecewise linear interpolator core
// depends on pli_pkg, pli_if, pli_result_check and the core
module tb_piecewise_linear_interpolator_core;

    localparam int NPTS      = 16;
    localparam int N_ITEMS   = 1500;
    localparam int SETTLE    = 100;
    localparam int LIMIT     = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = pli_pkg::CFG_COUNT;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          items = 0;
    int          burst_left = 0;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_count = 0;
    int          eff_n = 2;
    logic signed [31:0] tx [NPTS];

    pli_in_if  in_ch ();
    pli_out_if out_ch ();

    piecewise_linear_interpolator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    pli_result_check u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        in_ch.valid       = 1'b0;
        in_ch.action      = pli_pkg::ACT_LOAD;
        in_ch.point_index = '0;
        in_ch.point_x     = '0;
        in_ch.point_y     = '0;
        in_ch.sample_x    = '0;
        in_ch.last        = 1'b0;
        out_ch.ready      = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb_piecewise_linear_interpolator_core: errors");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen = hold_token;
            hold_left = 400;
        end
        rx_count++;
        if (rx_count % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (rx_mode == 0)
            out_ch.ready <= 1'b1;
        else if (rx_mode == 1)
            out_ch.ready <= 1'($urandom_range(0, 1));
        else if (rx_mode == 2)
            out_ch.ready <= ($urandom_range(0, 3) == 0);
        else
            out_ch.ready <= ($urandom_range(0, 7) != 0);
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic send(logic act, logic [3:0] idx, logic [31:0] px, logic [31:0] py,
                        logic [31:0] sx, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.point_index <= idx;
        in_ch.point_x     <= px;
        in_ch.point_y     <= py;
        in_ch.sample_x    <= sx;
        in_ch.last        <= lst;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
        items++;
        if (act == pli_pkg::ACT_LOAD)
            tx[idx] = px;
    endtask

    task automatic load_pt(int idx, logic [31:0] px, logic [31:0] py);
        send(pli_pkg::ACT_LOAD, idx[3:0], px, py, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic sample(logic [31:0] sx);
        send(pli_pkg::ACT_SAMPLE, 4'($urandom_range(0, 15)), $urandom, $urandom, sx,
             1'($urandom_range(0, 1)));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == pli_pkg::CFG_COUNT)
            eff_n = (val[4:0] < 2) ? 2 : ((val[4:0] > NPTS) ? NPTS : val[4:0]);
    endtask

    task automatic build_table;
        logic signed [31:0] xs [NPTS];
        logic signed [31:0] v;
        int                 shape;
        int                 j;
        longint             acc;
        int                 a;
        int                 b;
        shape = $urandom_range(0, 3);
        acc = longint'($signed($urandom));
        for (int i = 0; i < NPTS; i++)
        begin
            if (shape == 1)
            begin
                xs[i] = clamp32(acc);
                acc = acc + $urandom_range(1, 4000);
            end
            else
                xs[i] = $urandom;
        end
        if (shape != 1)
        begin
            for (int i = 1; i < NPTS; i++)
            begin
                v = xs[i];
                j = i - 1;
                while (j >= 0 && xs[j] > v)
                begin
                    xs[j + 1] = xs[j];
                    j--;
                end
                xs[j + 1] = v;
            end
        end
        if (shape == 2)
        begin
            a = $urandom_range(1, NPTS - 1);
            xs[a] = xs[a - 1];
        end
        if (shape == 3 && $urandom_range(0, 1))
        begin
            a = $urandom_range(0, NPTS - 2);
            b = a + 1;
            v = xs[a];
            xs[a] = xs[b];
            xs[b] = v;
        end
        for (int i = 0; i < NPTS; i++)
            if (i < eff_n || $urandom_range(0, 3) == 0)
                load_pt(i, xs[i], ($urandom_range(0, 9) == 0) ?
                        ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000) : $urandom);
    endtask

    function automatic logic [31:0] pick_x();
        int     r;
        int     k;
        longint lo;
        longint hi;
        longint span;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, eff_n - 2);
        lo = tx[k];
        hi = tx[k + 1];
        span = hi - lo;
        case (r)
            0, 1: return $urandom;
            2, 3: return tx[$urandom_range(0, eff_n - 1)];
            8: return clamp32(longint'(tx[0]) - $urandom_range(0, 3));
            9: return clamp32(longint'(tx[eff_n - 1]) + $urandom_range(0, 3) - 1);
            default:
            begin
                if (span > 0)
                    return clamp32(lo + longint'({$urandom, $urandom} % span));
                return tx[k];
            end
        endcase
    endfunction

    initial
    begin
        int ph;
        int ns;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full table with extremes and an equal-x pair
        cfg_write(pli_pkg::CFG_COUNT, 32'd16);
        cfg_write(pli_pkg::CFG_BELOW, 32'h80000000);
        cfg_write(pli_pkg::CFG_ABOVE, 32'h7fffffff);
        load_pt(0, 32'h80000000, 32'h7fffffff);
        for (int i = 1; i < NPTS - 1; i++)
            load_pt(i, (i - 8) * 32'sh10000000, $urandom);
        load_pt(NPTS - 1, 32'h7fffffff, 32'h80000000);
        load_pt(7, tx[6], 32'h00010000);
        sample(32'h80000000);
        sample(32'h7fffffff);
        sample(tx[6]);
        sample(tx[1]);
        sample(32'h7ffffffe);
        sample(32'hffffffff);
        drain();

        ph = 0;
        while (items < N_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1: cfg_write(pli_pkg::CFG_COUNT, 32'd2);
                2, 3: cfg_write(pli_pkg::CFG_COUNT, 32'd16);
                4: cfg_write(pli_pkg::CFG_COUNT, $urandom_range(0, 31));
                default: cfg_write(pli_pkg::CFG_COUNT, $urandom_range(2, 16));
            endcase
            cfg_write(pli_pkg::CFG_BELOW, (ph % 4 == 1) ? 32'h80000000 : $urandom);
            cfg_write(pli_pkg::CFG_ABOVE, (ph % 4 == 2) ? 32'h7fffffff : $urandom);
            build_table();
            if (ph == 3)
                hold_token++;
            ns = $urandom_range(20, 60);
            for (int i = 0; i < ns; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_pt($urandom_range(0, NPTS - 1), $urandom, $urandom);
                else
                    sample(pick_x());
            end
            drain();
            ph++;
        end

        if (errors == 0 && pending == 0)
            $display("tb_piecewise_linear_interpolator_core: clean");
        else
            $display("tb_piecewise_linear_interpolator_core: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pli_pkg.sv
hdl/pli_if.sv
hdl/pli_cell.sv
hdl/pli_div.sv
hdl/piecewise_linear_interpolator_core.sv
bench/pli_result_check.sv
bench/tb_piecewise_linear_interpolator_core.sv
